// ===== hw/rtl/ssm_pkg.sv =====
// ssm_pkg: shared types and constants for the substring stream matcher.
// Used by ssm_pattern_cfg and substring_stream_matcher; no dependencies.
`default_nettype none

package ssm_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int WORD_BITS      = 64;
    localparam int PAT_WORDS      = 4;
    localparam int PAT_SLOTS      = PAT_WORDS * WORD_BITS / BYTE_BITS;
    localparam int SLOT_BITS      = 5;
    localparam int LEN_BITS       = 6;
    localparam int CFG_INDEX_BITS = 3;
    localparam int OUT_POS_BITS   = 16;

    typedef logic [BYTE_BITS-1:0] byte_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PAT_LO     = 3'd0,
        CFG_PAT_MID_LO = 3'd1,
        CFG_PAT_MID_HI = 3'd2,
        CFG_PAT_HI     = 3'd3,
        CFG_PAT_LEN    = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ssm_pattern_cfg.sv =====
// ssm_pattern_cfg: pattern configuration registers, effective length and
// the pattern aligned to the text window. Depends on ssm_pkg.
`default_nettype none

module ssm_pattern_cfg #(
    parameter int MAX_PATTERN_BYTES = 32
) (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire logic                                              cfg_write,
    input  wire logic [ssm_pkg::CFG_INDEX_BITS-1:0]                cfg_index,
    input  wire logic [ssm_pkg::WORD_BITS-1:0]                     cfg_data,
    output logic      [ssm_pkg::LEN_BITS-1:0]                      pat_len,
    output logic      [MAX_PATTERN_BYTES-1:0][ssm_pkg::BYTE_BITS-1:0] pat_aligned
);

    logic [ssm_pkg::PAT_WORDS-1:0][ssm_pkg::WORD_BITS-1:0] words_reg;
    logic [ssm_pkg::LEN_BITS-1:0]                          len_reg;
    logic [ssm_pkg::PAT_SLOTS-1:0][ssm_pkg::BYTE_BITS-1:0] pat_bytes;
    logic [ssm_pkg::LEN_BITS-1:0]                          capped_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg <= '0;
            len_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (ssm_pkg::cfg_reg_t'(cfg_index))
                ssm_pkg::CFG_PAT_LO:     words_reg[0] <= cfg_data;
                ssm_pkg::CFG_PAT_MID_LO: words_reg[1] <= cfg_data;
                ssm_pkg::CFG_PAT_MID_HI: words_reg[2] <= cfg_data;
                ssm_pkg::CFG_PAT_HI:     words_reg[3] <= cfg_data;
                ssm_pkg::CFG_PAT_LEN:    len_reg      <= cfg_data[ssm_pkg::LEN_BITS-1:0];
                default:                 ;
            endcase
        end
    end

    assign pat_bytes = words_reg;

    // length capped at the maximum, then cut at the first zero byte
    always_comb
    begin
        capped_len = (len_reg > ssm_pkg::LEN_BITS'(MAX_PATTERN_BYTES))
                     ? ssm_pkg::LEN_BITS'(MAX_PATTERN_BYTES) : len_reg;
        pat_len = capped_len;
        for (int i = MAX_PATTERN_BYTES - 1; i >= 0; i--)
        begin
            if ((ssm_pkg::LEN_BITS'(i) < capped_len) && (pat_bytes[i] == '0))
            begin
                pat_len = ssm_pkg::LEN_BITS'(i);
            end
        end
    end

    // window slot k (0 newest) lines up with pattern byte len-1-k
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            pat_aligned[k] = pat_bytes[ssm_pkg::SLOT_BITS'(
                pat_len - ssm_pkg::LEN_BITS'(k + 1))];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/substring_stream_matcher.sv =====
// substring_stream_matcher: first occurrence of a byte pattern in a stream
// of zero-terminated strings. Depends on ssm_pkg and ssm_pattern_cfg.
//
//   channel  dir  handshake                 payload
//   text     in   text_valid / text_stall   text_byte
//   result   out  result_valid/result_stall found, match_position,
//                                           position_saturated
//   cfg      in   cfg_write                 cfg_index, cfg_data
//
// One byte per cycle sustained unless result_stall holds a full result register;
// each byte goes to the input register, then is compared into the result register.
// All window slots are compared in parallel against the aligned pattern.
// Reset clears control state; the window needs no clearing.
// result_stall holds the result register; text_stall rises only when the
// input register is full and the result register cannot drain.
`default_nettype none

module substring_stream_matcher #(
    parameter int MAX_PATTERN_BYTES = 32,
    parameter int POSITION_BITS     = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [ssm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [ssm_pkg::WORD_BITS-1:0]       cfg_data,
    input  wire logic                                text_valid,
    output logic                                     text_stall,
    input  wire logic [ssm_pkg::BYTE_BITS-1:0]       text_byte,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic                                     found,
    output logic      [ssm_pkg::OUT_POS_BITS-1:0]    match_position,
    output logic                                     position_saturated
);

    logic                                                 in_valid_reg, in_valid_next;
    ssm_pkg::byte_t                                       in_byte_reg;
    logic [MAX_PATTERN_BYTES-1:0][ssm_pkg::BYTE_BITS-1:0] window_reg, window_next;
    logic [MAX_PATTERN_BYTES-1:0][ssm_pkg::BYTE_BITS-1:0] shifted;
    logic [MAX_PATTERN_BYTES-1:0][ssm_pkg::BYTE_BITS-1:0] pat_aligned;
    logic [ssm_pkg::LEN_BITS-1:0]                         pat_len;
    logic [POSITION_BITS-1:0]                             count_reg, count_next, bumped;
    logic [POSITION_BITS-1:0]                             len_wide;
    logic                                                 given_reg, given_next;
    logic                                                 sat_reg, sat_next, sat_bump;
    logic                                                 out_valid_reg, out_valid_next;
    logic                                                 found_reg, found_next;
    logic                                                 osat_reg, osat_next;
    logic [ssm_pkg::OUT_POS_BITS-1:0]                     pos_reg, pos_next;
    logic [MAX_PATTERN_BYTES-1:0]                         lane_ok;
    logic                                                 res_ready, proc, in_accept;
    logic                                                 emit, hit, is_term;

    ssm_pattern_cfg #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pat_len     (pat_len),
        .pat_aligned (pat_aligned)
    );

    assign res_ready  = !out_valid_reg || !result_stall;
    assign proc       = in_valid_reg && res_ready;
    assign text_stall = in_valid_reg && !res_ready;
    assign in_accept  = text_valid && !text_stall;
    assign in_valid_next = in_accept || (in_valid_reg && !proc);

    assign is_term  = (in_byte_reg == '0);
    assign len_wide = POSITION_BITS'(pat_len);
    assign bumped   = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign sat_bump = sat_reg || (&count_reg);

    always_comb
    begin
        shifted[0] = in_byte_reg;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++)
        begin
            shifted[k] = window_reg[k-1];
        end
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            lane_ok[k] = (ssm_pkg::LEN_BITS'(k) >= pat_len) || (shifted[k] == pat_aligned[k]);
        end
    end

    assign hit = (&lane_ok) && (bumped >= len_wide);

    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        given_next  = given_reg;
        sat_next    = sat_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        osat_next   = osat_reg;
        emit        = 1'b0;
        if (proc)
        begin
            priority if (given_reg)
            begin
                if (is_term)
                begin
                    count_next = '0;
                    given_next = 1'b0;
                    sat_next   = 1'b0;
                end
            end
            else if (pat_len == '0)
            begin
                emit       = 1'b1;
                found_next = 1'b1;
                pos_next   = '0;
                osat_next  = sat_reg;
                if (is_term)
                begin
                    count_next = '0;
                    sat_next   = 1'b0;
                end
                else
                begin
                    given_next = 1'b1;
                end
            end
            else if (is_term)
            begin
                emit       = 1'b1;
                found_next = 1'b0;
                pos_next   = '0;
                osat_next  = sat_reg;
                count_next = '0;
                given_next = 1'b0;
                sat_next   = 1'b0;
            end
            else
            begin
                window_next = shifted;
                count_next  = bumped;
                sat_next    = sat_bump;
                if (hit)
                begin
                    emit       = 1'b1;
                    found_next = 1'b1;
                    pos_next   = ssm_pkg::OUT_POS_BITS'(bumped - len_wide);
                    osat_next  = sat_bump;
                    given_next = 1'b1;
                end
            end
        end
    end

    assign out_valid_next = emit || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            given_reg     <= 1'b0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            given_reg     <= given_next;
            sat_reg       <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= text_byte;
        end
        window_reg <= window_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        osat_reg   <= osat_next;
    end

    assign result_valid       = out_valid_reg;
    assign found              = found_reg;
    assign match_position     = pos_reg;
    assign position_saturated = osat_reg;

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && is_term) |=> (count_reg == '0 && !given_reg && !sat_reg))
        else $error("terminator did not clear string state");

    a_found_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !is_term) |=> given_reg)
        else $error("result on a text byte did not mark the string done");

    a_miss_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !found_next) |-> is_term)
        else $error("not-found result without a terminator");

    a_no_second_result: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && given_reg) |-> !emit)
        else $error("second result for one string");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost a pending transaction");

endmodule

`default_nettype wire

// ===== test/ssm_checker.sv =====
// ssm_checker: predicts and checks results of substring_stream_matcher.
// Watches the cfg, text and result channels; depends on ssm_pkg only.
`timescale 1ns / 1ps

module ssm_checker
    import ssm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data,
    input  logic                      text_valid,
    input  logic                      text_stall,
    input  logic [BYTE_BITS-1:0]      text_byte,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  logic                      found,
    input  logic [OUT_POS_BITS-1:0]   match_position,
    input  logic                      position_saturated,
    output int                        failures,
    output int                        pending
);

    localparam int WINDOW   = 32;
    localparam int MAX_LEN  = 32;
    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                    found;
        logic [OUT_POS_BITS-1:0] pos;
        logic                    sat;
    } verdict_t;

    logic [WORD_BITS-1:0] pat_word [PAT_WORDS];
    logic [LEN_BITS-1:0]  pat_len;
    byte_t                window [WINDOW];
    logic [POS_BITS-1:0]  seen;
    logic                 answered;
    logic                 saturated;
    verdict_t             verdict_q [$];

    function automatic byte_t pat_byte(int i);
        return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // pattern ends at the configured length or at its first zero byte
    function automatic int live_length();
        int n;
        n = (pat_len > MAX_LEN) ? MAX_LEN : int'(pat_len);
        for (int i = 0; i < n; i++)
            if (pat_byte(i) == 0)
                return i;
        return n;
    endfunction

    task automatic clear_string();
        foreach (window[i])
            window[i] = '0;
        seen      = '0;
        answered  = 1'b0;
        saturated = 1'b0;
    endtask

    task automatic scan_byte(byte_t b);
        int       n;
        bit       hit;
        verdict_t v;
        n = live_length();
        if (answered)
        begin
            if (b == 0)
                clear_string();
            return;
        end
        if (n == 0 || b == 0)
        begin
            v.found = (n == 0);
            v.pos   = '0;
            v.sat   = saturated;
            verdict_q.push_back(v);
            if (b == 0)
                clear_string();
            else
                answered = 1'b1;
            return;
        end
        for (int i = WINDOW - 1; i > 0; i--)
            window[i] = window[i - 1];
        window[0] = b;
        if (seen == COUNT_MAX)
            saturated = 1'b1;
        else
            seen = seen + 1'b1;
        if (int'(seen) < n)
            return;
        hit = 1'b1;
        for (int i = 0; i < n; i++)
            if (window[n - 1 - i] != pat_byte(i))
                hit = 1'b0;
        if (hit)
        begin
            v.found = 1'b1;
            v.pos   = OUT_POS_BITS'(int'(seen) - n);
            v.sat   = saturated;
            verdict_q.push_back(v);
            answered = 1'b1;
        end
    endtask

    task automatic check_result();
        verdict_t v;
        if (verdict_q.size() == 0)
        begin
            $error("result transaction with none expected: found=%0d match_position=%0d position_saturated=%0d",
                   found, match_position, position_saturated);
            failures++;
            return;
        end
        v = verdict_q.pop_front();
        if (found !== v.found)
        begin
            $error("found: expected %0d, actual %0d", v.found, found);
            failures++;
        end
        if (match_position !== v.pos)
        begin
            $error("match_position: expected %0d, actual %0d", v.pos, match_position);
            failures++;
        end
        if (position_saturated !== v.sat)
        begin
            $error("position_saturated: expected %0d, actual %0d", v.sat, position_saturated);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (pat_word[i])
                pat_word[i] = '0;
            pat_len = '0;
            clear_string();
            verdict_q.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_PAT_LO:     pat_word[0] = cfg_data;
                    CFG_PAT_MID_LO: pat_word[1] = cfg_data;
                    CFG_PAT_MID_HI: pat_word[2] = cfg_data;
                    CFG_PAT_HI:     pat_word[3] = cfg_data;
                    CFG_PAT_LEN:    pat_len = cfg_data[LEN_BITS-1:0];
                    default:        ;
                endcase
            end
            if (result_valid && !result_stall)
                check_result();
            if (text_valid && !text_stall)
                scan_byte(text_byte);
            pending <= verdict_q.size();
        end
    end

endmodule

// ===== test/tb_substring_stream_matcher.sv =====
// tb_substring_stream_matcher: stimulus and verdict for substring_stream_matcher.
// Drives pattern configs and text strings with random gaps and result stalls;
// checking is done by ssm_checker. Depends on ssm_pkg and the RTL.
`timescale 1ns / 1ps

module tb_substring_stream_matcher;
    import ssm_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 500;
    localparam int MAX_LEN      = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 3'd7;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [WORD_BITS-1:0]      cfg_data = '0;
    logic                      text_valid = 1'b0;
    logic                      text_stall;
    logic [BYTE_BITS-1:0]      text_byte = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic                      found;
    logic [OUT_POS_BITS-1:0]   match_position;
    logic                      position_saturated;
    int                        failures;
    int                        pending;

    bit                   quiet = 1'b0;
    int                   stall_left = 0;
    int                   idle_cycles = 0;
    int                   bytes_sent = 0;
    logic [WORD_BITS-1:0] pw [PAT_WORDS];
    logic [LEN_BITS-1:0]  cur_len;
    byte_t                alpha [3];
    byte_t                txt [$];

    always #5 clk = ~clk;

    substring_stream_matcher dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .text_valid         (text_valid),
        .text_stall         (text_stall),
        .text_byte          (text_byte),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .found              (found),
        .match_position     (match_position),
        .position_saturated (position_saturated)
    );

    ssm_checker match_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .text_valid         (text_valid),
        .text_stall         (text_stall),
        .text_byte          (text_byte),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .found              (found),
        .match_position     (match_position),
        .position_saturated (position_saturated),
        .failures           (failures),
        .pending            (pending)
    );

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left   <= pick_gap();
        end
    end

    // no transaction on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_valid && !text_stall) || (result_valid && !result_stall) || cfg_write)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input byte_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        do
            @(posedge clk);
        while (text_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input byte_t s [$]);
        foreach (s[i])
            send_byte(s[i]);
        send_byte('0);
    endtask

    // lower valid, wait for all results, then let in-flight bytes retire
    task automatic settle();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_pattern(input logic [LEN_BITS-1:0] len, input bit touch_spare);
        logic [WORD_BITS-1:0] len_word;
        len_word = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
        len_word[LEN_BITS-1:0] = len;
        cur_len = len;
        cfg_write <= 1'b1;
        cfg_index <= CFG_PAT_LO;
        cfg_data  <= pw[0];
        @(posedge clk);
        cfg_index <= CFG_PAT_MID_LO;
        cfg_data  <= pw[1];
        @(posedge clk);
        cfg_index <= CFG_PAT_MID_HI;
        cfg_data  <= pw[2];
        @(posedge clk);
        cfg_index <= CFG_PAT_HI;
        cfg_data  <= pw[3];
        @(posedge clk);
        cfg_index <= CFG_PAT_LEN;
        cfg_data  <= len_word;
        @(posedge clk);
        if (touch_spare)
        begin
            cfg_index <= CFG_SPARE;
            cfg_data  <= {$urandom, $urandom};
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic random_string();
        byte_t motif [$];
        byte_t s [$];
        byte_t b;
        int    n;
        int    cut;
        n = (cur_len > MAX_LEN) ? MAX_LEN : int'(cur_len);
        for (int i = 0; i < n; i++)
        begin
            b = pw[i / 8][(i % 8) * 8 +: 8];
            if (b == 0)
                break;
            motif.push_back(b);
        end
        if ($urandom_range(0, 9) < 7)
        begin
            repeat ($urandom_range(0, 10)) s.push_back(alpha[$urandom_range(0, 2)]);
            cut = motif.size();
            if (cut > 0 && $urandom_range(0, 3) == 0)
                cut = $urandom_range(0, cut - 1);
            for (int i = 0; i < cut; i++)
                s.push_back(motif[i]);
            repeat ($urandom_range(0, 10)) s.push_back(alpha[$urandom_range(0, 2)]);
        end
        else
            repeat ($urandom_range(0, 24)) s.push_back(byte_t'($urandom_range(1, 255)));
        send_text(s);
    endtask

    task automatic random_phase();
        logic [LEN_BITS-1:0] len;
        int                  p;
        quiet = ($urandom_range(0, 4) == 0);
        foreach (alpha[i])
            alpha[i] = byte_t'($urandom_range(1, 255));
        case ($urandom_range(0, 11))
            0:       len = '0;
            1:       len = LEN_BITS'(32);
            2:       len = LEN_BITS'(63);
            3:       len = LEN_BITS'($urandom_range(33, 62));
            4:       len = LEN_BITS'(1);
            default: len = LEN_BITS'($urandom_range(2, 8));
        endcase
        for (int i = 0; i < MAX_LEN; i++)
            pw[i / 8][(i % 8) * 8 +: 8] = alpha[$urandom_range(0, 2)];
        if ($urandom_range(0, 7) == 0)
        begin
            p = $urandom_range(0, 31);
            pw[p / 8][(p % 8) * 8 +: 8] = '0;
        end
        if ($urandom_range(0, 9) == 0)
            pw[$urandom_range(0, 3)] = {$urandom, $urandom};
        load_pattern(len, $urandom_range(0, 3) == 0);
        repeat ($urandom_range(3, 8)) random_string();
        settle();
    endtask

    initial
    begin
        foreach (pw[i])
            pw[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern straight out of reset
        txt.delete();
        send_text(txt);
        txt = {8'h41, 8'h42};
        send_text(txt);
        settle();

        pw = '{64'h6261, 64'h0, 64'h0, 64'h0};
        load_pattern(LEN_BITS'(2), 1'b1);
        txt = {8'h78, 8'h61, 8'h62};
        send_text(txt);
        txt = {8'h7a, 8'h7a};
        send_text(txt);
        settle();

        // zero byte cuts the pattern short
        pw = '{64'h63_00_62_61, 64'h0, 64'h0, 64'h0};
        load_pattern(LEN_BITS'(5), 1'b0);
        txt = {8'h63, 8'h61, 8'h62};
        send_text(txt);
        settle();

        // leading zero makes the pattern empty
        pw = '{64'h6100, 64'h0, 64'h0, 64'h0};
        load_pattern(LEN_BITS'(4), 1'b0);
        txt = {8'h71};
        send_text(txt);
        settle();

        pw = '{64'hff01, 64'h0, 64'h0, 64'h0};
        load_pattern(LEN_BITS'(2), 1'b0);
        txt = {8'hff, 8'h01, 8'hff};
        send_text(txt);
        settle();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
            random_phase();

        quiet = 1'b0;
        settle();
        if (failures == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
